// ===== sv/lbfv_pkg.sv =====
// Types, constants and fixed-width helpers for the four-vector boost pipeline.
// No dependencies; used by lorentz_boost_four_vector_top.
`default_nettype none

package lbfv_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int EPS_W = 25;
    localparam int IN_W = 384;
    localparam int OUT_W = 192;

    localparam logic [EPS_W-1:0] EPS_RESET = 25'd1;
    localparam logic [47:0] MAXPOS_MAG = 48'h7FFF_FFFF_FFFF;
    localparam logic [47:0] MAXNEG_MAG = 48'h8000_0000_0000;
    localparam logic signed [50:0] HI51 = 51'sd140737488355327;
    localparam logic signed [50:0] LO51 = -51'sd140737488355328;

    typedef struct packed {
        logic [3:0][47:0] v;
        logic [3:0][47:0] u;
    } item_t;

    typedef struct packed {
        logic        neg;
        logic [47:0] ll;
        logic [47:0] lh;
        logic [47:0] hl;
        logic [47:0] hh;
    } pp_t;

    typedef struct packed {
        logic        neg;
        logic [95:0] mag;
    } prod_t;

    typedef struct packed {
        logic        sat;
        logic [47:0] val;
    } res48_t;

    function automatic pp_t mul_pp(input logic [47:0] a, input logic [47:0] b);
        pp_t p;
        logic [47:0] ma;
        logic [47:0] mb;
        ma = a[47] ? (~a + 48'd1) : a;
        mb = b[47] ? (~b + 48'd1) : b;
        p.neg = a[47] ^ b[47];
        p.ll = 48'(ma[23:0]) * 48'(mb[23:0]);
        p.lh = 48'(ma[23:0]) * 48'(mb[47:24]);
        p.hl = 48'(ma[47:24]) * 48'(mb[23:0]);
        p.hh = 48'(ma[47:24]) * 48'(mb[47:24]);
        return p;
    endfunction

    function automatic prod_t pp_add(input pp_t p);
        prod_t r;
        r.neg = p.neg;
        r.mag = 96'(p.ll) + (96'(p.lh) << 24) + (96'(p.hl) << 24) + (96'(p.hh) << 48);
        return r;
    endfunction

    function automatic logic signed [50:0] sx51(input logic [47:0] x);
        return signed'({{3{x[47]}}, x});
    endfunction

    function automatic res48_t clamp51(input logic signed [50:0] s);
        res48_t r;
        r.sat = 1'b0;
        r.val = s[47:0];
        if (s > HI51)
        begin
            r.sat = 1'b1;
            r.val = MAXPOS_MAG;
        end
        else if (s < LO51)
        begin
            r.sat = 1'b1;
            r.val = MAXNEG_MAG;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== sv/lorentz_boost_four_vector_top.sv =====
// General Lorentz boost of a four-vector into the frame of a four-velocity, fully pipelined.
// Pipeline depth is set by the 48-step root and the (48 + FRAC_BITS)-step restoring
// dividers. Throughput: one request per cycle while the output is not held.
// The whole pipeline stalls together when the output is held. Reset clears all valid
// bits and sets guard_epsilon to one; no clearing pass.
// Depends on lbfv_pkg.
`default_nettype none

module lorentz_boost_four_vector_top #(
    parameter int FRAC_BITS = lbfv_pkg::FRAC_BITS_DEF
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [lbfv_pkg::EPS_W-1:0]  cfg_data,   // guard_epsilon
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // vec_t, vec_x, vec_y, vec_z, vel_gamma(47), vel_x, vel_y, vel_z, 1 pad bit
    input  wire logic [lbfv_pkg::IN_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    output logic [lbfv_pkg::OUT_W-1:0]       m_tdata,    // out_t, out_x, out_y, out_z
    output logic                             m_tuser     // saturated
);

    localparam int QB = 48 + FRAC_BITS;
    localparam int SQ_N = 48;
    localparam int K_SQ0 = 4;
    localparam int K_D = K_SQ0 + SQ_N;
    localparam int K_RA = K_D + 1 + QB;
    localparam int K_MP = K_RA + 5;
    localparam int K_FP = K_RA + 9;
    localparam int K_OUT = K_RA + 13;
    localparam logic [47:0] ONE48 = 48'(1) << FRAC_BITS;
    localparam logic [95:0] ONE2 = 96'(1) << (2 * FRAC_BITS);
    localparam logic [95:0] RND = 96'(1) << (FRAC_BITS - 1);

    function automatic lbfv_pkg::res48_t mul_rnd(input lbfv_pkg::prod_t p);
        lbfv_pkg::res48_t r;
        logic [95:0] q;
        logic [95:0] lim;
        q = (p.mag + RND) >> FRAC_BITS;
        lim = p.neg ? 96'(lbfv_pkg::MAXNEG_MAG) : 96'(lbfv_pkg::MAXPOS_MAG);
        r.sat = 1'b0;
        if (q > lim)
        begin
            r.sat = 1'b1;
            q = lim;
        end
        r.val = p.neg ? (~q[47:0] + 48'd1) : q[47:0];
        return r;
    endfunction

    logic                   adv;
    logic [lbfv_pkg::EPS_W-1:0] eps_reg;
    logic [lbfv_pkg::EPS_W-1:0] eps_eff;
    logic                   vld_reg [0:K_OUT];
    lbfv_pkg::item_t        cr_reg [0:K_FP-1];

    assign adv = !vld_reg[K_OUT] || m_tready;
    assign s_tready = adv;
    assign cfg_ready = 1'b1;
    assign m_tvalid = vld_reg[K_OUT];
    assign eps_eff = (eps_reg == '0) ? lbfv_pkg::EPS_RESET : eps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= lbfv_pkg::EPS_RESET;
        end
        else if (cfg_valid)
        begin
            eps_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= K_OUT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= s_tvalid;
            for (int k = 1; k <= K_OUT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cr_reg[0].v[0] <= s_tdata[47:0];
            cr_reg[0].v[1] <= s_tdata[95:48];
            cr_reg[0].v[2] <= s_tdata[143:96];
            cr_reg[0].v[3] <= s_tdata[191:144];
            cr_reg[0].u[0] <= {1'b0, s_tdata[238:192]};
            cr_reg[0].u[1] <= s_tdata[286:239];
            cr_reg[0].u[2] <= s_tdata[334:287];
            cr_reg[0].u[3] <= s_tdata[382:335];
            for (int k = 1; k < K_FP; k++)
            begin
                cr_reg[k] <= cr_reg[k-1];
            end
        end
    end

    // gamma^2 and |gamma^2 - 1|
    lbfv_pkg::pp_t gpp_reg;
    logic [95:0]   g2_reg;
    logic [95:0]   diff_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            gpp_reg <= lbfv_pkg::mul_pp(cr_reg[0].u[0], cr_reg[0].u[0]);
            g2_reg <= lbfv_pkg::pp_add(gpp_reg).mag;
            diff_reg <= (g2_reg >= ONE2) ? (g2_reg - ONE2) : (ONE2 - g2_reg);
        end
    end

    // integer square root, one result bit per stage
    logic [47:0] sr_root_reg [0:SQ_N-1];
    logic [95:0] sr_sq_reg [0:SQ_N-1];
    logic [95:0] sr_x_reg [0:SQ_N-1];

    for (genvar i = 0; i < SQ_N; i++)
    begin : g_sqrt
        localparam int B = SQ_N - 1 - i;
        logic [47:0] root_in;
        logic [95:0] sq_in;
        logic [95:0] x_in;
        logic [95:0] trial;
        if (i == 0)
        begin : g_first
            assign root_in = '0;
            assign sq_in = '0;
            assign x_in = diff_reg;
        end
        else
        begin : g_next
            assign root_in = sr_root_reg[i-1];
            assign sq_in = sr_sq_reg[i-1];
            assign x_in = sr_x_reg[i-1];
        end
        assign trial = sq_in + (96'(root_in) << (B + 1)) + (96'(1) << (2 * B));
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                sr_x_reg[i] <= x_in;
                if (trial <= x_in)
                begin
                    sr_root_reg[i] <= root_in | (48'(1) << B);
                    sr_sq_reg[i] <= trial;
                end
                else
                begin
                    sr_root_reg[i] <= root_in;
                    sr_sq_reg[i] <= sq_in;
                end
            end
        end
    end

    logic [47:0] d_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            d_reg <= sr_root_reg[SQ_N-1] + 48'(eps_eff);
        end
    end

    // three restoring dividers, one quotient bit per stage
    logic [47:0]   dv_reg [0:QB-1];
    logic [QB-1:0] dnum_reg [0:QB-1][0:2];
    logic [QB-1:0] dquo_reg [0:QB-1][0:2];
    logic [47:0]   drem_reg [0:QB-1][0:2];
    logic          dneg_reg [0:QB-1][0:2];

    for (genvar j = 0; j < QB; j++)
    begin : g_div
        logic [47:0] d_in;
        if (j == 0)
        begin : g_d0
            assign d_in = d_reg;
        end
        else
        begin : g_dn
            assign d_in = dv_reg[j-1];
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                dv_reg[j] <= d_in;
            end
        end
        for (genvar l = 0; l < 3; l++)
        begin : g_lane
            logic [QB-1:0] num_in;
            logic [QB-1:0] quo_in;
            logic [47:0]   rem_in;
            logic          neg_in;
            logic [48:0]   t;
            logic          ge;
            logic [48:0]   t_sub;
            if (j == 0)
            begin : g_l0
                logic [47:0] u_in;
                assign u_in = cr_reg[K_D].u[l+1];
                assign num_in = QB'(u_in[47] ? (~u_in + 48'd1) : u_in) << FRAC_BITS;
                assign quo_in = '0;
                assign rem_in = '0;
                assign neg_in = u_in[47];
            end
            else
            begin : g_ln
                assign num_in = dnum_reg[j-1][l];
                assign quo_in = dquo_reg[j-1][l];
                assign rem_in = drem_reg[j-1][l];
                assign neg_in = dneg_reg[j-1][l];
            end
            assign t = {rem_in, num_in[QB-1]};
            assign ge = t >= {1'b0, d_in};
            assign t_sub = t - {1'b0, d_in};
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dnum_reg[j][l] <= num_in << 1;
                    dquo_reg[j][l] <= {quo_in[QB-2:0], ge};
                    drem_reg[j][l] <= ge ? t_sub[47:0] : t[47:0];
                    dneg_reg[j][l] <= neg_in;
                end
            end
        end
    end

    // rounding of the unit direction
    logic [QB-1:0] ra_q_reg [0:2];
    logic          ra_rnd_reg [0:2];
    logic          ra_neg_reg [0:2];
    logic [47:0]   n_reg [0:2];
    logic          sat_rb_reg;
    logic [47:0]   n_next [0:2];
    logic          sat_rb_next;

    always_comb
    begin
        logic [QB:0] qq;
        logic [QB:0] lim;
        sat_rb_next = 1'b0;
        for (int l = 0; l < 3; l++)
        begin
            qq = (QB+1)'(ra_q_reg[l]) + (QB+1)'(ra_rnd_reg[l]);
            lim = ra_neg_reg[l] ? (QB+1)'(lbfv_pkg::MAXNEG_MAG)
                                : (QB+1)'(lbfv_pkg::MAXPOS_MAG);
            if (qq > lim)
            begin
                sat_rb_next = 1'b1;
                qq = lim;
            end
            n_next[l] = ra_neg_reg[l] ? (~qq[47:0] + 48'd1) : qq[47:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int l = 0; l < 3; l++)
            begin
                ra_q_reg[l] <= dquo_reg[QB-1][l];
                ra_rnd_reg[l] <= drem_reg[QB-1][l] >= (dv_reg[QB-1] - drem_reg[QB-1][l]);
                ra_neg_reg[l] <= dneg_reg[QB-1][l];
                n_reg[l] <= n_next[l];
            end
            sat_rb_reg <= sat_rb_next;
        end
    end

    // n_i * n_j, then times gamma - 1, then the diagonal
    lbfv_pkg::pp_t   np_reg [0:8];
    lbfv_pkg::prod_t ns_reg [0:8];
    logic [47:0]     nr_reg [0:8];
    lbfv_pkg::pp_t   mp_reg [0:8];
    lbfv_pkg::prod_t ms_reg [0:8];
    logic [47:0]     mr_reg [0:8];
    logic [47:0]     md_reg [0:8];
    logic sat_np_reg, sat_ns_reg, sat_nr_reg, sat_mp_reg, sat_ms_reg, sat_mr_reg, sat_md_reg;
    logic [47:0]     nr_next [0:8];
    logic [47:0]     mr_next [0:8];
    logic [47:0]     md_next [0:8];
    logic            sat_nr_next, sat_mr_next, sat_md_next;
    logic [47:0]     gm1;

    assign gm1 = cr_reg[K_MP-1].u[0] - ONE48;

    always_comb
    begin
        lbfv_pkg::res48_t r;
        sat_nr_next = sat_ns_reg;
        sat_mr_next = sat_ms_reg;
        sat_md_next = sat_mr_reg;
        for (int x = 0; x < 9; x++)
        begin
            r = mul_rnd(ns_reg[x]);
            nr_next[x] = r.val;
            sat_nr_next = sat_nr_next | r.sat;
            r = mul_rnd(ms_reg[x]);
            mr_next[x] = r.val;
            sat_mr_next = sat_mr_next | r.sat;
            if (x == 0 || x == 4 || x == 8)
            begin
                r = lbfv_pkg::clamp51(lbfv_pkg::sx51(mr_reg[x]) + lbfv_pkg::sx51(ONE48));
                md_next[x] = r.val;
                sat_md_next = sat_md_next | r.sat;
            end
            else
            begin
                md_next[x] = mr_reg[x];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int x = 0; x < 9; x++)
            begin
                np_reg[x] <= lbfv_pkg::mul_pp(n_reg[x / 3], n_reg[x % 3]);
                ns_reg[x] <= lbfv_pkg::pp_add(np_reg[x]);
                nr_reg[x] <= nr_next[x];
                mp_reg[x] <= lbfv_pkg::mul_pp(nr_reg[x], gm1);
                ms_reg[x] <= lbfv_pkg::pp_add(mp_reg[x]);
                mr_reg[x] <= mr_next[x];
                md_reg[x] <= md_next[x];
            end
            sat_np_reg <= sat_rb_reg;
            sat_ns_reg <= sat_np_reg;
            sat_nr_reg <= sat_nr_next;
            sat_mp_reg <= sat_nr_reg;
            sat_ms_reg <= sat_mp_reg;
            sat_mr_reg <= sat_mr_next;
            sat_md_reg <= sat_md_next;
        end
    end

    // matrix-vector products: 0..8 m*v, 9..12 u_k*v_k, 13..15 u_i*t
    lbfv_pkg::pp_t   fp_reg [0:15];
    lbfv_pkg::prod_t fs_reg [0:15];
    logic [47:0]     fr_reg [0:15];
    logic signed [50:0] sum_reg [0:3];
    logic [47:0]     out_reg [0:3];
    logic sat_fp_reg, sat_fs_reg, sat_fr_reg, sat_sum_reg, sat_out_reg;
    lbfv_pkg::pp_t   fp_next [0:15];
    logic [47:0]     fr_next [0:15];
    logic signed [50:0] sum_next [0:3];
    logic [47:0]     out_next [0:3];
    logic            sat_fr_next, sat_out_next;

    always_comb
    begin
        lbfv_pkg::res48_t r;
        lbfv_pkg::item_t  c;
        c = cr_reg[K_FP-1];
        for (int x = 0; x < 9; x++)
        begin
            fp_next[x] = lbfv_pkg::mul_pp(md_reg[x], c.v[(x % 3) + 1]);
        end
        for (int k = 0; k < 4; k++)
        begin
            fp_next[9 + k] = lbfv_pkg::mul_pp(c.u[k], c.v[k]);
        end
        for (int i = 0; i < 3; i++)
        begin
            fp_next[13 + i] = lbfv_pkg::mul_pp(c.u[i + 1], c.v[0]);
        end
        sat_fr_next = sat_fs_reg;
        for (int x = 0; x < 16; x++)
        begin
            r = mul_rnd(fs_reg[x]);
            fr_next[x] = r.val;
            sat_fr_next = sat_fr_next | r.sat;
        end
        sum_next[0] = lbfv_pkg::sx51(fr_reg[9]) - lbfv_pkg::sx51(fr_reg[10])
                    - lbfv_pkg::sx51(fr_reg[11]) - lbfv_pkg::sx51(fr_reg[12]);
        for (int i = 0; i < 3; i++)
        begin
            sum_next[i + 1] = lbfv_pkg::sx51(fr_reg[3 * i]) + lbfv_pkg::sx51(fr_reg[3 * i + 1])
                            + lbfv_pkg::sx51(fr_reg[3 * i + 2])
                            - lbfv_pkg::sx51(fr_reg[13 + i]);
        end
        sat_out_next = sat_sum_reg;
        for (int k = 0; k < 4; k++)
        begin
            r = lbfv_pkg::clamp51(sum_reg[k]);
            out_next[k] = r.val;
            sat_out_next = sat_out_next | r.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int x = 0; x < 16; x++)
            begin
                fp_reg[x] <= fp_next[x];
                fs_reg[x] <= lbfv_pkg::pp_add(fp_reg[x]);
                fr_reg[x] <= fr_next[x];
            end
            for (int k = 0; k < 4; k++)
            begin
                sum_reg[k] <= sum_next[k];
                out_reg[k] <= out_next[k];
            end
            sat_fp_reg <= sat_md_reg;
            sat_fs_reg <= sat_fp_reg;
            sat_fr_reg <= sat_fr_next;
            sat_sum_reg <= sat_fr_reg;
            sat_out_reg <= sat_out_next;
        end
    end

    assign m_tdata = {out_reg[3], out_reg[2], out_reg[1], out_reg[0]};
    assign m_tuser = sat_out_reg;

endmodule

`default_nettype wire
